/* sv/deq_pkg.sv */
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and constants for the double-ended queue: operation codes,
// status codes, controller states and the per-cell control bundle.
// ----------------------------------------------------------------------------
package deq_pkg;

  // default configuration
  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  // operation carried by each input item
  typedef enum logic [1:0] {
    MODE_PUSH_FRONT = 2'd0,
    MODE_PUSH_BACK  = 2'd1,
    MODE_POP_FRONT  = 2'd2,
    MODE_POP_BACK   = 2'd3
  } mode_t;

  // completion status of an operation
  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_UNDER = 2'd1,
    STATUS_OVER  = 2'd2
  } status_t;

  // controller states
  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_GATHER = 1'b1
  } state_t;

  // operation strobes broadcast to every cell, already qualified by full/empty
  typedef struct packed {
    logic push_front;
    logic push_back;
    logic pop_front;
    logic pop_back;
  } deq_ctl_t;

endpackage

/* sv/deq_cell.sv */
// ----------------------------------------------------------------------------
// deq_cell
// One slot of the shifting queue. Cells form a row with the front entry in
// cell zero; each cell trades its word with its neighbors on front operations
// and fills or empties itself at the boundary on back operations.
// ----------------------------------------------------------------------------
module deq_cell
  import deq_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  deq_ctl_t              ctl,
  input  logic [DATA_WIDTH-1:0] push_value,
  input  logic [DATA_WIDTH-1:0] left_data,
  input  logic                  left_valid,
  input  logic [DATA_WIDTH-1:0] right_data,
  input  logic                  right_valid,
  output logic [DATA_WIDTH-1:0] data,
  output logic                  valid,
  output logic [DATA_WIDTH-1:0] back_word
);

  logic [DATA_WIDTH-1:0] data_r, data_nxt;
  logic                  valid_r, valid_nxt;
  logic                  is_last;

  // this cell holds the back entry
  assign is_last = valid_r && !right_valid;

  // next contents of the slot
  always_comb begin
    data_nxt  = data_r;
    valid_nxt = valid_r;
    if (ctl.push_front) begin
      data_nxt  = left_data;
      valid_nxt = left_valid;
    end else if (ctl.pop_front) begin
      data_nxt  = right_data;
      valid_nxt = right_valid;
    end else if (ctl.push_back) begin
      if (!valid_r && left_valid) begin
        data_nxt  = push_value;
        valid_nxt = 1'b1;
      end
    end else if (ctl.pop_back) begin
      if (is_last) begin
        valid_nxt = 1'b0;
      end
    end
  end

  // occupancy flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // stored word
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data      = data_r;
  assign valid     = valid_r;
  assign back_word = is_last ? data_r : '0;

endmodule

/* sv/double_ended_queue.sv */
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded deque of DEPTH words held in a row of shifting cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: in_tuser selects the operation (push front, push back,
//   pop front, pop back), in_tdata carries the word to push. Each item
//   produces exactly one result item on the output stream with the popped
//   word, the front and back words after the operation, the entry count,
//   an empty flag (all in out_tdata) and a status code in out_tuser.
//   A push into a full queue is dropped with overflow status; a pop of an
//   empty queue is refused with underflow status and zero popped word.
// Timing:
//   An accepted item updates the cell row in the same edge; the next cycle
//   gathers the back word from the cells and loads the output register.
//   in_tready stays low during the gather, so a new item is accepted only
//   after the back-word gather across the cell row for the last one is done.
// Reset:
//   rst_n empties the queue and drops any pending result.
// Backpressure:
//   The result register holds until taken; a new item is accepted while a
//   held result is being taken in the same cycle, otherwise in_tready stays
//   low until the output register is free.
// ----------------------------------------------------------------------------
module double_ended_queue
  import deq_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  localparam int CNT_W     = $clog2(DEPTH + 1),
  localparam int IN_W      = ((DATA_WIDTH + 7) / 8) * 8,
  localparam int OUT_BITS  = 3 * DATA_WIDTH + CNT_W + 1,
  localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // value
  input  logic [1:0]       in_tuser,   // mode
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata,  // popped_value, front_value, back_value,
                                       // entry_count, is_empty
  output logic [1:0]       out_tuser   // status
);

  localparam int PAD_W = OUT_W - OUT_BITS;

  state_t                state_r, state_nxt;
  logic                  in_acc;
  logic                  gather_en;
  mode_t                 in_mode;
  logic [DATA_WIDTH-1:0] in_value;
  logic                  full, empty;
  deq_ctl_t              ctl;

  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [DATA_WIDTH-1:0] back_r;
  logic [DATA_WIDTH-1:0] popped_r, popped_nxt;
  status_t               status_r, status_nxt;

  logic                  out_tvalid_r;
  logic [DATA_WIDTH-1:0] out_popped_r, out_front_r, out_back_r;
  logic [CNT_W-1:0]      out_count_r;
  logic                  out_empty_r;
  status_t               out_status_r;

  logic [DATA_WIDTH-1:0] cell_data  [DEPTH];
  logic                  cell_valid [DEPTH];
  logic [DATA_WIDTH-1:0] cell_back  [DEPTH];
  logic [DATA_WIDTH-1:0] back_gather;

  assign in_mode  = mode_t'(in_tuser);
  assign in_value = in_tdata[DATA_WIDTH-1:0];
  assign in_acc   = in_tvalid && in_tready;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);

  // controller outputs
  always_comb begin
    in_tready = 1'b0;
    gather_en = 1'b0;
    case (state_r)
      ST_IDLE:   in_tready = !out_tvalid_r || out_tready;
      ST_GATHER: gather_en = 1'b1;
      default:   ;
    endcase
  end

  // controller next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_acc) state_nxt = ST_GATHER;
      ST_GATHER: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // qualified operation strobes for the cell row
  always_comb begin
    ctl.push_front = in_acc && (in_mode == MODE_PUSH_FRONT) && !full;
    ctl.push_back  = in_acc && (in_mode == MODE_PUSH_BACK)  && !full;
    ctl.pop_front  = in_acc && (in_mode == MODE_POP_FRONT)  && !empty;
    ctl.pop_back   = in_acc && (in_mode == MODE_POP_BACK)   && !empty;
  end

  // popped word, status and entry count for the accepted item
  always_comb begin
    popped_nxt = popped_r;
    status_nxt = status_r;
    count_nxt  = count_r;
    if (in_acc) begin
      popped_nxt = '0;
      status_nxt = STATUS_OK;
      case (in_mode)
        MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
          if (full) status_nxt = STATUS_OVER;
          else      count_nxt  = count_r + 1'b1;
        end
        MODE_POP_FRONT: begin
          if (empty) begin
            status_nxt = STATUS_UNDER;
          end else begin
            popped_nxt = cell_data[0];
            count_nxt  = count_r - 1'b1;
          end
        end
        MODE_POP_BACK: begin
          if (empty) begin
            status_nxt = STATUS_UNDER;
          end else begin
            popped_nxt = back_r;
            count_nxt  = count_r - 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // row of cells, front entry in cell zero
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_data, right_data;
    logic                  left_valid, right_valid;

    if (i == 0) begin : g_head
      assign left_data  = in_value;
      assign left_valid = 1'b1;
    end else begin : g_mid_l
      assign left_data  = cell_data[i-1];
      assign left_valid = cell_valid[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_data  = '0;
      assign right_valid = 1'b0;
    end else begin : g_mid_r
      assign right_data  = cell_data[i+1];
      assign right_valid = cell_valid[i+1];
    end

    deq_cell #(
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .push_value  (in_value),
      .left_data   (left_data),
      .left_valid  (left_valid),
      .right_data  (right_data),
      .right_valid (right_valid),
      .data        (cell_data[i]),
      .valid       (cell_valid[i]),
      .back_word   (cell_back[i])
    );
  end

  // only the last occupied cell drives a nonzero back word
  always_comb begin
    back_gather = '0;
    for (int i = 0; i < DEPTH; i++) begin
      back_gather = back_gather | cell_back[i];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      back_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (gather_en) begin
        back_r       <= back_gather;
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // per-item payload and result register
  always_ff @(posedge clk) begin
    popped_r <= popped_nxt;
    status_r <= status_nxt;
    if (gather_en) begin
      out_popped_r <= popped_r;
      out_front_r  <= cell_valid[0] ? cell_data[0] : '0;
      out_back_r   <= back_gather;
      out_count_r  <= count_r;
      out_empty_r  <= (count_r == '0);
      out_status_r <= status_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_status_r;
  if (PAD_W > 0) begin : g_pad
    assign out_tdata = {{PAD_W{1'b0}}, out_empty_r, out_count_r,
                        out_back_r, out_front_r, out_popped_r};
  end else begin : g_nopad
    assign out_tdata = {out_empty_r, out_count_r, out_back_r, out_front_r, out_popped_r};
  end

endmodule

/* sv/deq_checker.sv */
// ----------------------------------------------------------------------------
// deq_checker
// Port-level checks for the double-ended queue, bound to the top level.
// ----------------------------------------------------------------------------
module deq_checker
  import deq_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  localparam int CNT_W     = $clog2(DEPTH + 1),
  localparam int OUT_BITS  = 3 * DATA_WIDTH + CNT_W + 1,
  localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata,
  input logic [1:0]       out_tuser
);

  localparam int CNT_LO = 3 * DATA_WIDTH;
  localparam int EMP_B  = 3 * DATA_WIDTH + CNT_W;

  logic [DATA_WIDTH-1:0] popped;
  logic [CNT_W-1:0]      count;
  logic                  is_empty;

  assign popped   = out_tdata[DATA_WIDTH-1:0];
  assign count    = out_tdata[EMP_B-1:CNT_LO];
  assign is_empty = out_tdata[EMP_B];

  // a stalled result item holds its contents
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result item changed while stalled");

  // every accepted item yields a result item once the gather state has run
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |-> ##2 out_tvalid)
    else $error("result item missing after accept");

  // empty flag agrees with the entry count and the count stays in range
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (is_empty == (count == '0)) && (count <= CNT_W'(DEPTH)))
    else $error("empty flag or count inconsistent");

  // refused pops return a zero word and leave the deque empty
  a_under: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == STATUS_UNDER) |-> (popped == '0) && is_empty)
    else $error("underflow result carries data");

endmodule

bind double_ended_queue deq_checker #(
  .DEPTH      (DEPTH),
  .DATA_WIDTH (DATA_WIDTH)
) u_deq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
